### rtl/aspq_pkg.sv
`timescale 1ns / 1ps
package aspq_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned IdW      = 31;
  localparam int unsigned ScoreW   = 32;
  localparam int unsigned AgeW     = 16;
  localparam logic [AgeW-1:0] AgeLimit = '1;
  localparam logic signed [ScoreW-1:0] NoScore = -32'sd1;
  localparam logic signed [ScoreW-1:0] ScoreMax = 32'sh7FFF_FFFF;
  localparam logic signed [ScoreW-1:0] ScoreMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_RN_WR
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]           key;
    logic signed [ScoreW-1:0] total;
    logic [AgeW-1:0]          age;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

### rtl/aspq_if.sv
`timescale 1ns / 1ps
interface aspq_req_if;
  import aspq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [IdW-1:0]           item_id;
  logic signed [ScoreW-1:0] score_delta;
  modport source (output valid, opcode, item_id, score_delta, input ready);
  modport sink   (input valid, opcode, item_id, score_delta, output ready);
endinterface

interface aspq_rsp_if;
  import aspq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [IdW-1:0]           result_id;
  logic signed [ScoreW-1:0] result_score;
  modport source (output valid, status, result_id, result_score, input ready);
  modport sink   (input valid, status, result_id, result_score, output ready);
endinterface

### rtl/aspq_ram.sv
`timescale 1ns / 1ps
module aspq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/additive_score_priority_queue_core.sv
`timescale 1ns / 1ps
// Keyed max priority queue of up to Capacity items (id + saturating signed
// score). Entries live in one single-port-read/single-port-write RAM; valid
// and scratch bits are flops. Every operation is one full sweep of the RAM:
// one read issued per cycle, then the registered read data, then write-back
// and response. Update finds the id or the lowest free slot, pop/peek find
// the highest score with the oldest stamp winning ties, query finds the id.
// When the 16-bit stamp counter hits its limit the block renumbers live
// stamps in age order: one sweep plus one write per live item plus a closing
// sweep, during which no transfer is accepted. Reads and writes never overlap
// in time (the FSM sweeps, then writes), so no forwarding is needed.
module additive_score_priority_queue_core
  import aspq_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  aspq_req_if.sink   in_i,
  aspq_rsp_if.source out_o
);

  state_e state_q, state_d;

  logic [CntW-1:0]     cnt_q, cnt_d;      // read issue pointer
  logic                rd_vld_q;          // rdata holds valid read data this cycle
  logic [IdxW-1:0]     rd_idx_q;
  logic                rn_q, rn_d;        // sweep is a renumber pass
  logic [CntW-1:0]     rank_q, rank_d;

  logic [Capacity-1:0] valid_q, valid_d;
  logic [Capacity-1:0] done_q, done_d;
  logic [AgeW-1:0]     age_q, age_d;

  // latched request
  op_e                      op_q;
  logic [IdW-1:0]           key_q;
  logic signed [ScoreW-1:0] delta_q;

  // sweep trackers
  logic                     hit_q, hit_d;
  logic [IdxW-1:0]          hit_idx_q, hit_idx_d;
  logic signed [ScoreW-1:0] hit_tot_q, hit_tot_d;
  logic                     free_q, free_d;
  logic [IdxW-1:0]          free_idx_q, free_idx_d;
  logic                     best_q, best_d;
  logic [IdxW-1:0]          best_idx_q, best_idx_d;
  entry_t                   best_ent_q, best_ent_d;

  // output register
  logic                     ovld_q, ovld_d;
  status_e                  ost_q, ost_d;
  logic [IdW-1:0]           oid_q, oid_d;
  logic signed [ScoreW-1:0] osc_q, osc_d;

  // RAM
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata, rdata;
  logic [IdxW-1:0] raddr;

  aspq_ram #(.Width(EntryW), .Depth(Capacity)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic issue;
  logic last_rd;
  logic out_free;
  logic signed [ScoreW:0] sum_w;
  logic signed [ScoreW-1:0] base, sum_sat;
  logic [AgeW-1:0] age_inc;

  assign issue    = (state_q == S_SCAN) && (cnt_q < CntW'(Capacity));
  assign raddr    = cnt_q[IdxW-1:0];
  assign last_rd  = rd_vld_q && (rd_idx_q == IdxW'(Capacity - 1));
  assign out_free = !ovld_q || out_o.ready;
  assign age_inc  = age_q + AgeW'(1);

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = ovld_q;
  assign out_o.status       = ost_q;
  assign out_o.result_id    = oid_q;
  assign out_o.result_score = osc_q;

  // saturating add on the base score picked at write-back
  always_comb begin
    base = hit_q ? hit_tot_q : '0;
    sum_w = {base[ScoreW-1], base} + {delta_q[ScoreW-1], delta_q};
    if (sum_w > (ScoreW+1)'(ScoreMax)) begin
      sum_sat = ScoreMax;
    end else if (sum_w < (ScoreW+1)'(ScoreMin)) begin
      sum_sat = ScoreMin;
    end else begin
      sum_sat = sum_w[ScoreW-1:0];
    end
  end

  always_comb begin
    logic live;
    logic better;
    state_d    = state_q;
    cnt_d      = cnt_q;
    rn_d       = rn_q;
    rank_d     = rank_q;
    valid_d    = valid_q;
    done_d     = done_q;
    age_d      = age_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_tot_d  = hit_tot_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    best_ent_d = best_ent_q;
    ovld_d     = ovld_q && !out_o.ready;
    ost_d      = ost_q;
    oid_d      = oid_q;
    osc_d      = osc_q;
    we         = 1'b0;
    waddr      = hit_idx_q;
    wdata      = '{key: key_q, total: sum_sat, age: age_q};
    live       = valid_q[rd_idx_q];
    better     = 1'b0;

    // sweep bookkeeping on returning read data
    if (rd_vld_q) begin
      if (rn_q) begin
        better = live && !done_q[rd_idx_q] && (!best_q || rdata.age < best_ent_q.age);
      end else begin
        better = live && (!best_q || rdata.total > best_ent_q.total ||
                 (rdata.total == best_ent_q.total && rdata.age < best_ent_q.age));
        if (live && rdata.key == key_q && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = rd_idx_q;
          hit_tot_d = rdata.total;
        end
        if (!live && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = rd_idx_q;
        end
      end
      if (better) begin
        best_d     = 1'b1;
        best_idx_d = rd_idx_q;
        best_ent_d = rdata;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_SCAN;
          cnt_d   = '0;
          rn_d    = 1'b0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          best_d  = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (last_rd) begin
          state_d = rn_q ? S_RN_WR : S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          oid_d   = key_q;
          state_d = S_IDLE;
          unique case (op_q)
            OP_UPDATE: begin
              if (hit_q || free_q) begin
                we      = 1'b1;
                waddr   = hit_q ? hit_idx_q : free_idx_q;
                ost_d   = hit_q ? ST_FOUND : ST_ADDED;
                osc_d   = sum_sat;
                valid_d[waddr] = 1'b1;
                age_d   = age_inc;
                if (age_inc == AgeLimit) begin
                  state_d = S_SCAN;
                  rn_d    = 1'b1;
                  cnt_d   = '0;
                  rank_d  = '0;
                  best_d  = 1'b0;
                  done_d  = '0;
                end
              end else begin
                ost_d = ST_FULL;
                osc_d = NoScore;
              end
            end
            OP_POP, OP_PEEK: begin
              if (best_q) begin
                ost_d = ST_FOUND;
                oid_d = best_ent_q.key;
                osc_d = best_ent_q.total;
                if (op_q == OP_POP) begin
                  valid_d[best_idx_q] = 1'b0;
                end
              end else begin
                ost_d = ST_NOTFOUND;
                osc_d = NoScore;
              end
            end
            OP_QUERY: begin
              ost_d = hit_q ? ST_FOUND : ST_NOTFOUND;
              osc_d = hit_q ? hit_tot_q : NoScore;
            end
            default: ;
          endcase
        end
      end
      S_RN_WR: begin
        // write the next-oldest live entry with its rank, or finish
        if (best_q) begin
          we      = 1'b1;
          waddr   = best_idx_q;
          wdata   = '{key: best_ent_q.key, total: best_ent_q.total, age: AgeW'(rank_q)};
          done_d[best_idx_q] = 1'b1;
          rank_d  = rank_q + CntW'(1);
          state_d = S_SCAN;
          cnt_d   = '0;
          best_d  = 1'b0;
        end else begin
          age_d   = AgeW'(rank_q);
          rn_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rn_q     <= 1'b0;
      rank_q   <= '0;
      valid_q  <= '0;
      done_q   <= '0;
      age_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      best_q   <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= issue;
      rn_q     <= rn_d;
      rank_q   <= rank_d;
      valid_q  <= valid_d;
      done_q   <= done_d;
      age_q    <= age_d;
      hit_q    <= hit_d;
      free_q   <= free_d;
      best_q   <= best_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= raddr;
    hit_idx_q  <= hit_idx_d;
    hit_tot_q  <= hit_tot_d;
    free_idx_q <= free_idx_d;
    best_idx_q <= best_idx_d;
    best_ent_q <= best_ent_d;
    ost_q      <= ost_d;
    oid_q      <= oid_d;
    osc_q      <= osc_d;
    if (in_i.valid && in_i.ready) begin
      op_q    <= op_e'(in_i.opcode);
      key_q   <= in_i.item_id;
      delta_q <= in_i.score_delta;
    end
  end

  // stamp counter never rests at its limit between operations
  a_age_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> age_q != AgeLimit) else $error("stamp at limit");

  // RAM is only written outside sweeps
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> !issue && !rd_vld_q) else $error("write during sweep");

  // a response is only produced at write-back
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q) == S_FIN) else $error("stray response");

  // a pop that found an item frees that entry
  a_pop_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free && op_q == OP_POP && best_q)
      |=> !valid_q[$past(best_idx_q)]) else $error("pop left entry");

endmodule
